FILE: rtl/core/wsd_pkg.sv
package wsd_pkg;

  // Parse phase of the frame header and payload walk
  typedef enum logic [2:0] {
    PH_BYTE0   = 3'd0,
    PH_BYTE1   = 3'd1,
    PH_EXT16   = 3'd2,
    PH_EXT64   = 3'd3,
    PH_MASK    = 3'd4,
    PH_PAYLOAD = 3'd5
  } phase_t;

  // 7-bit length codes that select an extended length
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // Index of the final byte of each multi-byte header field
  localparam logic [2:0] EXT16_LAST = 3'd1;
  localparam logic [2:0] EXT64_LAST = 3'd7;
  localparam logic [2:0] MASK_LAST  = 3'd3;

endpackage

FILE: rtl/core/wsd_byte_if.sv
interface wsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

FILE: rtl/core/wsd_result_if.sv
interface wsd_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       last_in_frame;
  logic [3:0] frame_opcode;
  logic       fin_flag;

  modport source (
    output valid, output payload_byte, output last_in_frame,
    output frame_opcode, output fin_flag, input ready
  );
  modport sink (
    input valid, input payload_byte, input last_in_frame,
    input frame_opcode, input fin_flag, output ready
  );
endinterface

FILE: rtl/core/websocket_frame_deframer.sv
// Channel  Dir  Payload                                           Role
// stream   in   in_byte[7:0]                                      raw frame bytes
// result   out  payload_byte, last_in_frame, frame_opcode, fin    unmasked payload
//
// Each accepted byte updates the parse state in the same cycle, and a payload byte
// lands in the output register in the cycle after its transfer. The output register
// is the only buffer: a new byte is taken while it is empty or being drained in the
// same cycle, so throughput is one byte per cycle unless the result side stalls.
// Header bytes produce no result. rst (synchronous) returns to the first header byte.
module websocket_frame_deframer (
  input  logic          clk,
  input  logic          rst,
  wsd_byte_if.sink      stream,
  wsd_result_if.source  result
);

  wsd_pkg::phase_t phase, phase_next;
  logic [2:0]  hdr_count, hdr_count_next;
  logic [3:0]  held_opcode, held_opcode_next;
  logic        held_fin, held_fin_next;
  logic        masked, masked_next;
  logic [31:0] key_word, key_word_next;
  logic [63:0] remaining, remaining_next;
  logic [1:0]  mask_index, mask_index_next;

  logic        take;
  logic        emit;
  logic [63:0] len_shift;
  logic [7:0]  key_byte;
  logic        final_ext;

  // Accept while the output register is empty or being drained
  assign stream.ready = !result.valid || result.ready;
  assign take         = stream.valid && stream.ready;
  assign len_shift    = {remaining[55:0], stream.in_byte};

  // Select the key byte for the current payload position
  always_comb begin
    case (mask_index)
      2'd0:    key_byte = key_word[31:24];
      2'd1:    key_byte = key_word[23:16];
      2'd2:    key_byte = key_word[15:8];
      default: key_byte = key_word[7:0];
    endcase
    if (!masked) begin
      key_byte = 8'd0;
    end
  end

  // Next parse state for the accepted byte
  always_comb begin
    phase_next       = phase;
    hdr_count_next   = hdr_count;
    held_opcode_next = held_opcode;
    held_fin_next    = held_fin;
    masked_next      = masked;
    key_word_next    = key_word;
    remaining_next   = remaining;
    mask_index_next  = mask_index;
    emit             = 1'b0;
    final_ext        = 1'b0;
    case (phase)
      wsd_pkg::PH_BYTE1: begin
        masked_next     = stream.in_byte[7];
        mask_index_next = 2'd0;
        key_word_next   = 32'd0;
        remaining_next  = 64'd0;
        hdr_count_next  = 3'd0;
        if (stream.in_byte[6:0] == wsd_pkg::LEN_EXT16) begin
          phase_next = wsd_pkg::PH_EXT16;
        end else if (stream.in_byte[6:0] == wsd_pkg::LEN_EXT64) begin
          phase_next = wsd_pkg::PH_EXT64;
        end else begin
          remaining_next = {57'd0, stream.in_byte[6:0]};
          if (stream.in_byte[7]) begin
            phase_next = wsd_pkg::PH_MASK;
          end else if (stream.in_byte[6:0] != 7'd0) begin
            phase_next = wsd_pkg::PH_PAYLOAD;
          end else begin
            phase_next = wsd_pkg::PH_BYTE0;
          end
        end
      end
      wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
        remaining_next = len_shift;
        if (phase == wsd_pkg::PH_EXT16) begin
          final_ext = (hdr_count >= wsd_pkg::EXT16_LAST);
        end else begin
          final_ext = (hdr_count >= wsd_pkg::EXT64_LAST);
        end
        if (final_ext) begin
          hdr_count_next = 3'd0;
          if (masked) begin
            phase_next = wsd_pkg::PH_MASK;
          end else if (len_shift != 64'd0) begin
            phase_next = wsd_pkg::PH_PAYLOAD;
          end else begin
            phase_next = wsd_pkg::PH_BYTE0;
          end
        end else begin
          hdr_count_next = hdr_count + 3'd1;
        end
      end
      wsd_pkg::PH_MASK: begin
        key_word_next = {key_word[23:0], stream.in_byte};
        if (hdr_count >= wsd_pkg::MASK_LAST) begin
          hdr_count_next = 3'd0;
          phase_next     = (remaining != 64'd0) ? wsd_pkg::PH_PAYLOAD : wsd_pkg::PH_BYTE0;
        end else begin
          hdr_count_next = hdr_count + 3'd1;
        end
      end
      wsd_pkg::PH_PAYLOAD: begin
        emit            = 1'b1;
        mask_index_next = mask_index + 2'd1;
        remaining_next  = remaining - 64'd1;
        if (remaining == 64'd1) begin
          phase_next = wsd_pkg::PH_BYTE0;
        end
      end
      default: begin
        held_fin_next    = stream.in_byte[7];
        held_opcode_next = stream.in_byte[3:0];
        hdr_count_next   = 3'd0;
        phase_next       = wsd_pkg::PH_BYTE1;
      end
    endcase
  end

  // Advance parse state on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= wsd_pkg::PH_BYTE0;
      hdr_count   <= 3'd0;
      held_opcode <= 4'd0;
      held_fin    <= 1'b0;
      masked      <= 1'b0;
      key_word    <= 32'd0;
      remaining   <= 64'd0;
      mask_index  <= 2'd0;
    end else if (take) begin
      phase       <= phase_next;
      hdr_count   <= hdr_count_next;
      held_opcode <= held_opcode_next;
      held_fin    <= held_fin_next;
      masked      <= masked_next;
      key_word    <= key_word_next;
      remaining   <= remaining_next;
      mask_index  <= mask_index_next;
    end
  end

  // Load the output register on a payload byte, drop valid once drained
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (take && emit) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  // Hold the result payload until the next payload byte
  always_ff @(posedge clk) begin
    if (take && emit) begin
      result.payload_byte  <= stream.in_byte ^ key_byte;
      result.last_in_frame <= (remaining == 64'd1);
      result.frame_opcode  <= held_opcode;
      result.fin_flag      <= held_fin;
    end
  end

endmodule
